>>> sv/omni_wheel_inverse_kinematics_unit_assert.svh
// Assertion macros for the omni wheel inverse kinematics unit.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef OMNI_WHEEL_INVERSE_KINEMATICS_UNIT_ASSERT_SVH
`define OMNI_WHEEL_INVERSE_KINEMATICS_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define OWIK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owik assertion failed");

// Next-cycle implication, checked out of reset.
`define OWIK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owik assertion failed");

`endif

>>> sv/owik_pkg.sv
// Shared types, constants and fixed-point helpers of the omni wheel unit.
// No dependencies; used by the divider, the top level and the testbench.
`default_nettype none

package owik_pkg;

    // Q16.16 fraction bits and the value one in Q1.16.
    localparam int FRAC_BITS = 16;
    localparam logic [16:0] FACTOR_ONE = 17'd65536;

    // One restoring division step per pipeline stage.
    localparam int DIV_STEPS = 16;

    // Configuration register indexes (byte address bits [3:2]).
    localparam logic [1:0] REG_WHEEL_SCALE = 2'd0;
    localparam logic [1:0] REG_ROT_RADIUS  = 2'd1;
    localparam logic [1:0] REG_MAX_SPEED   = 2'd2;

    localparam logic [30:0] WHEEL_SCALE_RST = 31'd65536;
    localparam logic [30:0] ROT_RADIUS_RST  = 31'd32768;
    localparam logic [30:0] MAX_SPEED_RST   = 31'd131072;

    // Per-wheel division lane: quotient of rem * 2^16 / dvs, with rem < dvs.
    typedef struct packed {
        logic [47:0] rem;
        logic [47:0] dvs;
        logic [15:0] quo;
        logic        skip;   // wheel imposes no bound
        logic        zero;   // bound forces the factor to zero
    } lane_t;

    // Data that rides alongside the division lanes.
    typedef struct packed {
        logic             mode;
        logic [3:0][48:0] plain;  // signed plain-mode wheel values
        logic [46:0]      rot;    // signed rotation part times scale
        logic [47:0]      ta;     // signed (vx + vy) times scale
        logic [47:0]      tb;     // signed (vx - vy) times scale
    } side_t;

    // Drop 16 fraction bits of a product, rounding toward zero.
    function automatic logic signed [49:0] trunc16(input logic signed [65:0] p);
        logic signed [49:0] q;
        q = p[65:FRAC_BITS];
        if (p[65] && (p[FRAC_BITS-1:0] != '0))
            q = q + 50'sd1;
        return q;
    endfunction

    // Saturate to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] s;
        if (v > 50'sd2147483647)
            s = 32'sh7FFFFFFF;
        else if (v < -50'sd2147483648)
            s = 32'sh80000000;
        else
            s = v[31:0];
        return s;
    endfunction

    // One restoring division step: shift in a zero, subtract if it fits.
    function automatic lane_t div_step(input lane_t l);
        lane_t       n;
        logic [48:0] sh;
        logic        ge;
        n  = l;
        sh = {l.rem, 1'b0};
        ge = (sh >= {1'b0, l.dvs});
        if (ge)
            n.rem = 48'(sh - {1'b0, l.dvs});
        else
            n.rem = sh[47:0];
        n.quo = {l.quo[14:0], ge};
        return n;
    endfunction

endpackage

`default_nettype wire

>>> sv/owik_cmd_if.sv
// Body velocity command channel with valid/ready handshake.
// Stand-alone interface; no package dependency.
`default_nettype none

interface owik_cmd_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] forward_speed;
    logic signed [31:0] lateral_speed;
    logic signed [31:0] yaw_rate;

    modport source (output valid, mode, forward_speed, lateral_speed, yaw_rate,
                    input ready);
    modport sink   (input valid, mode, forward_speed, lateral_speed, yaw_rate,
                    output ready);
endinterface

`default_nettype wire

>>> sv/owik_wheel_if.sv
// Wheel speed target channel with valid/ready handshake.
// Stand-alone interface; no package dependency.
`default_nettype none

interface owik_wheel_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] front_left_speed;
    logic signed [31:0] front_right_speed;
    logic signed [31:0] rear_left_speed;
    logic signed [31:0] rear_right_speed;
    logic [16:0]        translation_factor;

    modport source (output valid, front_left_speed, front_right_speed,
                    rear_left_speed, rear_right_speed, translation_factor,
                    input ready);
    modport sink   (input valid, front_left_speed, front_right_speed,
                    rear_left_speed, rear_right_speed, translation_factor,
                    output ready);
endinterface

`default_nettype wire

>>> sv/owik_divider.sv
// Pipelined restoring divider: four lanes, one quotient bit per stage.
// Depends on owik_pkg for lane_t, side_t, div_step and DIV_STEPS.
`default_nettype none

module owik_divider (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire owik_pkg::lane_t [3:0]  in_lane,
    input  wire owik_pkg::side_t        in_side,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output owik_pkg::lane_t [3:0]       out_lane,
    output owik_pkg::side_t             out_side
);
    import owik_pkg::*;

    logic             valid_reg [DIV_STEPS];
    lane_t [3:0]      lane_reg  [DIV_STEPS];
    side_t            side_reg  [DIV_STEPS];
    logic [DIV_STEPS:0] en;

    // A stage may load when it is empty or its successor moves.
    always_comb
    begin
        en[DIV_STEPS] = out_ready;
        for (int k = DIV_STEPS - 1; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    assign in_ready = en[0];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
                valid_reg[k] <= 1'b0;
        end
        else
        begin
            if (en[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < DIV_STEPS; k++)
                if (en[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    // Each stage produces one more quotient bit per lane.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 4; i++)
                lane_reg[0][i] <= div_step(in_lane[i]);
            side_reg[0] <= in_side;
        end
        for (int k = 1; k < DIV_STEPS; k++)
            if (en[k])
            begin
                for (int i = 0; i < 4; i++)
                    lane_reg[k][i] <= div_step(lane_reg[k-1][i]);
                side_reg[k] <= side_reg[k-1];
            end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_lane  = lane_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

>>> sv/omni_wheel_inverse_kinematics_unit.sv
// Omni wheel inverse kinematics, one command accepted per cycle when the
// output keeps up. The path has 24 register stages: five setup stages, the
// 16-stage divider and three final stages. Each stage stalls only if full
// and its successor stalls.
// rst_n clears all valid bits and loads the register defaults at once.
// Depends on owik_pkg, owik_cmd_if, owik_wheel_if, owik_divider.
`default_nettype none

module omni_wheel_inverse_kinematics_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    owik_cmd_if.sink         cmd,
    owik_wheel_if.source     wheel,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import owik_pkg::*;

    // Configuration registers.
    logic [30:0] scale_reg;
    logic [30:0] radius_reg;
    logic [30:0] max_speed_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= WHEEL_SCALE_RST;
            radius_reg    <= ROT_RADIUS_RST;
            max_speed_reg <= MAX_SPEED_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_WHEEL_SCALE: scale_reg     <= pwdata[30:0];
                REG_ROT_RADIUS:  radius_reg    <= pwdata[30:0];
                REG_MAX_SPEED:   max_speed_reg <= pwdata[30:0];
                default:         ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_WHEEL_SCALE: prdata = {1'b0, scale_reg};
            REG_ROT_RADIUS:  prdata = {1'b0, radius_reg};
            REG_MAX_SPEED:   prdata = {1'b0, max_speed_reg};
            default:         prdata = '0;
        endcase
    end

    // Stage valid bits and load enables.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vmin_reg, vmul_reg, vout_reg;
    logic en1, en2, en3, en4, en5, enmin, enmul, enout;
    logic div_in_ready, div_out_valid;

    assign enout = !vout_reg || wheel.ready;
    assign enmul = !vmul_reg || enout;
    assign enmin = !vmin_reg || enmul;
    assign en5   = !v5_reg || div_in_ready;
    assign en4   = !v4_reg || en5;
    assign en3   = !v3_reg || en4;
    assign en2   = !v2_reg || en3;
    assign en1   = !v1_reg || en2;
    assign cmd.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            vmin_reg <= 1'b0;
            vmul_reg <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (en1)   v1_reg   <= cmd.valid;
            if (en2)   v2_reg   <= v1_reg;
            if (en3)   v3_reg   <= v2_reg;
            if (en4)   v4_reg   <= v3_reg;
            if (en5)   v5_reg   <= v4_reg;
            if (enmin) vmin_reg <= div_out_valid;
            if (enmul) vmul_reg <= vmin_reg;
            if (enout) vout_reg <= vmul_reg;
        end
    end

    // Stage 1: rotation product R * wz.
    logic               mode1_reg;
    logic signed [31:0] vx1_reg, vy1_reg;
    logic signed [65:0] rotp1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mode1_reg <= cmd.mode;
            vx1_reg   <= cmd.forward_speed;
            vy1_reg   <= cmd.lateral_speed;
            rotp1_reg <= cmd.yaw_rate * $signed({1'b0, radius_reg});
        end
    end

    // Stage 2: saturate rotation and form the wheel sums.
    logic               mode2_reg;
    logic signed [31:0] rot2_reg;
    logic signed [33:0] spp2_reg, smm2_reg, smp2_reg, spm2_reg;
    logic signed [32:0] ta2_reg, tb2_reg;
    logic signed [31:0] rot1;

    assign rot1 = sat32(trunc16(rotp1_reg));

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            mode2_reg <= mode1_reg;
            rot2_reg  <= rot1;
            spp2_reg  <= vx1_reg + vy1_reg + rot1;
            smm2_reg  <= vx1_reg - vy1_reg - rot1;
            smp2_reg  <= vx1_reg - vy1_reg + rot1;
            spm2_reg  <= vx1_reg + vy1_reg - rot1;
            ta2_reg   <= vx1_reg + vy1_reg;
            tb2_reg   <= vx1_reg - vy1_reg;
        end
    end

    // Stage 3: scale everything by the wheel factor.
    logic               mode3_reg;
    logic signed [65:0] pl3_reg [4];
    logic signed [65:0] r3_reg, ta3_reg, tb3_reg, lim3_reg;
    logic signed [31:0] scale_s;

    assign scale_s = $signed({1'b0, scale_reg});

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            mode3_reg  <= mode2_reg;
            pl3_reg[0] <= spp2_reg * scale_s;
            pl3_reg[1] <= smm2_reg * scale_s;
            pl3_reg[2] <= smp2_reg * scale_s;
            pl3_reg[3] <= spm2_reg * scale_s;
            r3_reg     <= rot2_reg * scale_s;
            ta3_reg    <= ta2_reg * scale_s;
            tb3_reg    <= tb2_reg * scale_s;
            lim3_reg   <= $signed({1'b0, max_speed_reg}) * scale_s;
        end
    end

    // Stage 4: drop the fraction bits.
    logic               mode4_reg;
    logic signed [48:0] pl4_reg [4];
    logic signed [46:0] r4_reg;
    logic signed [47:0] ta4_reg, tb4_reg;
    logic [45:0]        lim4_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            mode4_reg <= mode3_reg;
            for (int i = 0; i < 4; i++)
                pl4_reg[i] <= 49'(trunc16(pl3_reg[i]));
            r4_reg   <= 47'(trunc16(r3_reg));
            ta4_reg  <= 48'(trunc16(ta3_reg));
            tb4_reg  <= 48'(trunc16(tb3_reg));
            lim4_reg <= 46'(trunc16(lim3_reg));
        end
    end

    // Stage 5: per-wheel bound numerator and divisor.
    lane_t [3:0]        lane5_next;
    lane_t [3:0]        lane5_reg;
    side_t              side5_next;
    side_t              side5_reg;
    logic signed [47:0] tw4 [4];
    logic signed [47:0] rw4 [4];
    logic signed [48:0] num4 [4];
    logic [47:0]        mag4 [4];

    always_comb
    begin
        tw4[0] = ta4_reg;
        tw4[1] = tb4_reg;
        tw4[2] = tb4_reg;
        tw4[3] = ta4_reg;
        rw4[0] = 48'(r4_reg);
        rw4[1] = -48'(r4_reg);
        rw4[2] = 48'(r4_reg);
        rw4[3] = -48'(r4_reg);
        for (int i = 0; i < 4; i++)
        begin
            mag4[i] = tw4[i][47] ? 48'(-tw4[i]) : tw4[i];
            if (tw4[i][47])
                num4[i] = $signed({3'b000, lim4_reg}) + rw4[i];
            else
                num4[i] = $signed({3'b000, lim4_reg}) - rw4[i];
            lane5_next[i].rem  = num4[i][47:0];
            lane5_next[i].dvs  = mag4[i];
            lane5_next[i].quo  = '0;
            lane5_next[i].skip = (tw4[i] == '0) ||
                                 (num4[i] > 49'sd0 && num4[i] >= $signed({1'b0, mag4[i]}));
            lane5_next[i].zero = (tw4[i] != '0) && (num4[i] <= 49'sd0);
        end
        side5_next.mode = mode4_reg;
        for (int i = 0; i < 4; i++)
            side5_next.plain[i] = pl4_reg[i];
        side5_next.rot = r4_reg;
        side5_next.ta  = ta4_reg;
        side5_next.tb  = tb4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            lane5_reg <= lane5_next;
            side5_reg <= side5_next;
        end
    end

    // Quotient bits, one per stage.
    lane_t [3:0] dlane;
    side_t       dside;

    owik_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_ready  (div_in_ready),
        .in_lane   (lane5_reg),
        .in_side   (side5_reg),
        .out_valid (div_out_valid),
        .out_ready (enmin),
        .out_lane  (dlane),
        .out_side  (dside)
    );

    // Minimum over the wheel candidates.
    logic [16:0] cand [4];
    logic [16:0] fmin;
    logic [16:0] factor_reg;
    side_t       sidemin_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (dlane[i].skip)
                cand[i] = FACTOR_ONE;
            else if (dlane[i].zero)
                cand[i] = '0;
            else
                cand[i] = {1'b0, dlane[i].quo};
        end
        fmin = FACTOR_ONE;
        for (int i = 0; i < 4; i++)
            if (cand[i] < fmin)
                fmin = cand[i];
    end

    always_ff @(posedge clk)
    begin
        if (enmin)
        begin
            factor_reg  <= dside.mode ? fmin : FACTOR_ONE;
            sidemin_reg <= dside;
        end
    end

    // Scale the translation parts by the factor.
    logic signed [65:0] tprod_reg [4];
    logic [16:0]        factor_mul_reg;
    side_t              sidemul_reg;
    logic signed [17:0] factor_s;

    assign factor_s = $signed({1'b0, factor_reg});

    always_ff @(posedge clk)
    begin
        if (enmul)
        begin
            tprod_reg[0]   <= $signed(sidemin_reg.ta) * factor_s;
            tprod_reg[1]   <= $signed(sidemin_reg.tb) * factor_s;
            tprod_reg[2]   <= $signed(sidemin_reg.tb) * factor_s;
            tprod_reg[3]   <= $signed(sidemin_reg.ta) * factor_s;
            factor_mul_reg <= factor_reg;
            sidemul_reg    <= sidemin_reg;
        end
    end

    // Final sum and saturation into the output register.
    logic signed [31:0] wheel_next [4];
    logic signed [49:0] rwm [4];
    logic signed [31:0] out_reg [4];
    logic [16:0]        out_factor_reg;

    always_comb
    begin
        rwm[0] = 50'($signed(sidemul_reg.rot));
        rwm[1] = -50'($signed(sidemul_reg.rot));
        rwm[2] = 50'($signed(sidemul_reg.rot));
        rwm[3] = -50'($signed(sidemul_reg.rot));
        for (int i = 0; i < 4; i++)
        begin
            if (sidemul_reg.mode)
                wheel_next[i] = sat32(rwm[i] + trunc16(tprod_reg[i]));
            else
                wheel_next[i] = sat32(50'($signed(sidemul_reg.plain[i])));
        end
    end

    always_ff @(posedge clk)
    begin
        if (enout)
        begin
            for (int i = 0; i < 4; i++)
                out_reg[i] <= wheel_next[i];
            out_factor_reg <= factor_mul_reg;
        end
    end

    assign wheel.valid              = vout_reg;
    assign wheel.front_left_speed   = out_reg[0];
    assign wheel.front_right_speed  = out_reg[1];
    assign wheel.rear_left_speed    = out_reg[2];
    assign wheel.rear_right_speed   = out_reg[3];
    assign wheel.translation_factor = out_factor_reg;

    // Checks on the pipeline.
`include "omni_wheel_inverse_kinematics_unit_assert.svh"

    `OWIK_ASSERT_NOW(a_ready_only_on_stall, !cmd.ready, wheel.valid && !wheel.ready)
    `OWIK_ASSERT_NOW(a_factor_range, wheel.valid, wheel.translation_factor <= FACTOR_ONE)
    `OWIK_ASSERT_NOW(a_plain_factor_one, vmin_reg && !sidemin_reg.mode, factor_reg == FACTOR_ONE)

endmodule

`default_nettype wire

>>> test/omni_wheel_inverse_kinematics_unit_tb.sv
// Self-checking testbench for the omni wheel inverse kinematics unit.
// Drives commands and APB register writes, checks every wheel result against a table entry or an SV prediction.
// Depends on owik_pkg, owik_cmd_if, owik_wheel_if and the unit itself.
`timescale 1ns / 100ps

module omni_wheel_inverse_kinematics_unit_tb;
    import owik_pkg::*;

    typedef struct {
        logic signed [31:0] fl;
        logic signed [31:0] fr;
        logic signed [31:0] rl;
        logic signed [31:0] rr;
        logic [16:0]        factor;
    } wheel_set_t;

    typedef struct {
        bit                 mode;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] wz;
        bit                 fixed;
        wheel_set_t         want;
    } cmd_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    owik_cmd_if   cmd();
    owik_wheel_if wheel();

    omni_wheel_inverse_kinematics_unit DUT (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .wheel(wheel),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copies of the configuration registers.
    longint unsigned scale_q;
    longint unsigned radius_q;
    longint unsigned max_speed_q;

    wheel_set_t pending_wheels[$];
    int         mismatches;
    bit         send_idle_en;
    bit         recv_idle_en;
    bit         hold_off_req;
    int         idle_cycles;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Q16.16 product truncated toward zero.
    function automatic longint mulq(longint a, longint unsigned b);
        logic [127:0]    p;
        longint unsigned m;
        m = (a < 0) ? -a : a;
        p = {64'd0, m} * {64'd0, b};
        p = p >> 16;
        return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Wheel targets and translation factor for one body velocity command.
    function automatic wheel_set_t predict_wheels(bit mode, logic signed [31:0] vx_i,
                                                  logic signed [31:0] vy_i,
                                                  logic signed [31:0] wz_i);
        longint          vx;
        longint          vy;
        longint          rot;
        longint          r;
        longint          lim;
        longint          num;
        longint          rw[4];
        longint          tw[4];
        longint          w[4];
        longint unsigned fac;
        logic [127:0]    cand;
        wheel_set_t      res;
        vx  = vx_i;
        vy  = vy_i;
        rot = clamp32(mulq(longint'(wz_i), radius_q));
        fac = 65536;
        if (!mode)
        begin
            w[0] = mulq(vx + vy + rot, scale_q);
            w[1] = mulq(vx - vy - rot, scale_q);
            w[2] = mulq(vx - vy + rot, scale_q);
            w[3] = mulq(vx + vy - rot, scale_q);
        end
        else
        begin
            r     = mulq(rot, scale_q);
            lim   = mulq(longint'(max_speed_q), scale_q);
            rw[0] = r;
            rw[1] = -r;
            rw[2] = r;
            rw[3] = -r;
            tw[0] = mulq(vx + vy, scale_q);
            tw[3] = tw[0];
            tw[1] = mulq(vx - vy, scale_q);
            tw[2] = tw[1];
            // Each wheel with translation bounds the common factor.
            for (int i = 0; i < 4; i++)
            begin
                if (tw[i] != 0)
                begin
                    num = (tw[i] > 0) ? lim - rw[i] : lim + rw[i];
                    if (num <= 0)
                        fac = 0;
                    else
                    begin
                        cand = ({64'd0, num} << 16) / {64'd0, ((tw[i] < 0) ? -tw[i] : tw[i])};
                        if (cand < {64'd0, fac})
                            fac = cand[63:0];
                    end
                end
            end
            for (int i = 0; i < 4; i++)
                w[i] = rw[i] + mulq(tw[i], fac);
        end
        res.fl     = clamp32(w[0]);
        res.fr     = clamp32(w[1]);
        res.rl     = clamp32(w[2]);
        res.rr     = clamp32(w[3]);
        res.factor = fac[16:0];
        return res;
    endfunction

    // Random field value weighted toward extremes and moderate speeds.
    function automatic logic signed [31:0] rand_speed();
        case ($urandom_range(0, 9))
            0: return 32'sh80000000;
            1: return 32'sh7FFFFFFF;
            2: return 32'sd0;
            3, 4: return $urandom;
            default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
    endfunction

    // APB register write: setup cycle then access cycle.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WHEEL_SCALE: scale_q     = value[30:0];
            REG_ROT_RADIUS:  radius_q    = value[30:0];
            REG_MAX_SPEED:   max_speed_q = value[30:0];
            default: ;
        endcase
    endtask

    // Offer one command and hold it until the transfer happens.
    task automatic send_cmd(cmd_row_t row);
        while (send_idle_en && $urandom_range(0, 99) < 28)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid         <= 1'b1;
        cmd.mode          <= row.mode;
        cmd.forward_speed <= row.vx;
        cmd.lateral_speed <= row.vy;
        cmd.yaw_rate      <= row.wz;
        do
            @(posedge clk);
        while (!cmd.ready);
        if (row.fixed)
            pending_wheels.push_back(row.want);
        else
            pending_wheels.push_back(predict_wheels(row.mode, row.vx, row.vy, row.wz));
    endtask

    task automatic send_random(int count);
        cmd_row_t row;
        for (int n = 0; n < count; n++)
        begin
            row.mode  = $urandom_range(0, 3) != 0;
            row.vx    = rand_speed();
            row.vy    = rand_speed();
            row.wz    = rand_speed();
            row.fixed = 1'b0;
            send_cmd(row);
        end
    endtask

    // Stop offering and wait until every expected result has arrived.
    task automatic drain();
        cmd.valid <= 1'b0;
        while (pending_wheels.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Receiver ready, with random idling and an on-demand long hold-off.
    initial
    begin
        int hold_count;
        wheel.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                for (hold_count = 0; hold_count < 300; hold_count++)
                begin
                    wheel.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            wheel.ready <= !(recv_idle_en && $urandom_range(0, 99) < 28);
        end
    end

    // Result checker: every transfer against the oldest expectation.
    always @(posedge clk)
    begin
        wheel_set_t want;
        if (rst_n && wheel.valid && wheel.ready)
        begin
            if (pending_wheels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected wheel transfer at %0t", $realtime);
            end
            else
            begin
                want = pending_wheels.pop_front();
                if (wheel.front_left_speed !== want.fl || wheel.front_right_speed !== want.fr
                    || wheel.rear_left_speed !== want.rl || wheel.rear_right_speed !== want.rr
                    || wheel.translation_factor !== want.factor)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at %0t: exp %0d %0d %0d %0d f=%0d got %0d %0d %0d %0d f=%0d",
                                 $realtime, want.fl, want.fr, want.rl, want.rr, want.factor,
                                 wheel.front_left_speed, wheel.front_right_speed,
                                 wheel.rear_left_speed, wheel.rear_right_speed,
                                 wheel.translation_factor);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (wheel.valid && wheel.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 3000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        cmd_row_t   table_rows[$];
        cmd_row_t   row;
        wheel_set_t zero_set;
        mismatches   = 0;
        idle_cycles  = 0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        hold_off_req = 1'b0;
        scale_q      = 65536;
        radius_q     = 32768;
        max_speed_q  = 131072;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cmd.valid         = 1'b0;
        cmd.mode          = 1'b0;
        cmd.forward_speed = '0;
        cmd.lateral_speed = '0;
        cmd.yaw_rate      = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed commands: zero input in both modes has an obvious answer.
        zero_set = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, FACTOR_ONE};
        table_rows.push_back('{1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b1, zero_set});
        table_rows.push_back('{1'b1, 32'sd0, 32'sd0, 32'sd0, 1'b1, zero_set});
        table_rows.push_back('{1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, zero_set});
        table_rows.push_back('{1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, zero_set});
        table_rows.push_back('{1'b1, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 1'b0, zero_set});
        table_rows.push_back('{1'b1, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, zero_set});
        // Pure rotation past the limit, and pure rotation within it.
        table_rows.push_back('{1'b1, 32'sd0, 32'sd0, 32'sh7FFFFFFF, 1'b0, zero_set});
        table_rows.push_back('{1'b1, 32'sd0, 32'sd0, 32'sd65536, 1'b0, zero_set});
        // Translation on one diagonal only leaves the other unbounded, then mixed commands.
        table_rows.push_back('{1'b1, 32'sd65536, 32'sd65536, 32'sd0, 1'b0, zero_set});
        table_rows.push_back('{1'b1, 32'sd196608, -32'sd196608, 32'sd32768, 1'b0, zero_set});
        table_rows.push_back('{1'b1, 32'sd262144, 32'sd0, -32'sd131072, 1'b0, zero_set});
        table_rows.push_back('{1'b1, -32'sd262144, 32'sd65536, 32'sd200000, 1'b0, zero_set});
        table_rows.push_back('{1'b1, 32'sd65536, 32'sd0, 32'sd0, 1'b0, zero_set});
        table_rows.push_back('{1'b0, -32'sd1, 32'sd1, -32'sd1, 1'b0, zero_set});
        foreach (table_rows[i])
            send_cmd(table_rows[i]);
        drain();

        // Register extremes: everything zero, then everything maximal.
        write_reg(REG_WHEEL_SCALE, 32'd0);
        write_reg(REG_ROT_RADIUS, 32'd0);
        write_reg(REG_MAX_SPEED, 32'd0);
        send_random(60);
        drain();
        write_reg(REG_WHEEL_SCALE, 32'hFFFFFFFF);
        write_reg(REG_ROT_RADIUS, 32'h7FFFFFFF);
        write_reg(REG_MAX_SPEED, 32'h7FFFFFFF);
        send_random(60);
        drain();

        // Typical chassis: the receiver holds off while commands keep coming.
        write_reg(REG_WHEEL_SCALE, 32'd92682);
        write_reg(REG_ROT_RADIUS, 32'd26214);
        write_reg(REG_MAX_SPEED, 32'd98304);
        hold_off_req = 1'b1;
        send_random(200);
        // The sender pauses until every result is home.
        drain();
        send_random(100);
        drain();

        // A stretch with no idling on either side.
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        write_reg(REG_MAX_SPEED, 32'd20000);
        send_random(200);
        drain();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;

        // Random settings.
        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_WHEEL_SCALE, $urandom_range(0, 1 << 19));
            write_reg(REG_ROT_RADIUS, $urandom_range(0, 1 << 18));
            write_reg(REG_MAX_SPEED, (p == 3) ? $urandom : $urandom_range(0, 1 << 19));
            send_random(100);
            drain();
        end

        if (mismatches == 0 && pending_wheels.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
